>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the search unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// Types and sizing constants of the substring index search unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssi_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int MAX_TEXT    = 65535;
  localparam int CHAR_BITS   = 32;

  localparam int IN_CHAR_W = 32;
  localparam int POS_W     = 17;
  localparam int ERR_W     = 2;
  localparam int PCNT_W    = $clog2(MAX_PATTERN + 1);
  localparam int TEXT_W    = $clog2(MAX_TEXT + 2);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic step;
  } cell_ctl_t;

  typedef struct packed {
    logic match;
    logic match_nxt;
  } cell_stat_t;

endpackage

`default_nettype wire

>>> hdl/substring_index_search_unit.sv
// ----------------------------------------------------------------------------
// substring_index_search_unit
// Streaming INDEX search: a row of prefix cells tracks the first and last
// start of a full pattern match and reports one at end of text.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle of any kind while in_stall is low; every cell compares the text
//   character in the same cycle and passes its match bit to the next cell.
// Result: shows on out_ in the cycle after the end-of-text beat is accepted.
// Reset: clears pattern count, match cells, text count, matches, flags and
//   the output valid; pattern characters are undefined until appended.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module substring_index_search_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       in_operation,
  input  wire logic [ssi_pkg::IN_CHAR_W-1:0]    in_char_value,
  input  wire logic                             in_search_backward,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [ssi_pkg::POS_W-1:0]             out_match_position,
  output logic [ssi_pkg::ERR_W-1:0]             out_error_code
);

  localparam int NP = ssi_pkg::MAX_PATTERN;
  localparam int PW = ssi_pkg::PCNT_W;
  localparam int TW = ssi_pkg::TEXT_W;

  logic                          in_acc;
  ssi_pkg::op_t                  op;
  logic [ssi_pkg::CHAR_BITS-1:0] chr;

  logic [PW-1:0] pcount_r, pcount_nxt;
  logic [TW-1:0] text_r, text_nxt;
  logic [TW-1:0] first_r, first_nxt;
  logic [TW-1:0] last_r, last_nxt;
  logic          pat_ovf_r, pat_ovf_nxt;
  logic          txt_ovf_r, txt_ovf_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [ssi_pkg::POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [ssi_pkg::ERR_W-1:0] out_err_r, out_err_nxt;

  logic          step;
  logic          hit;
  logic [TW-1:0] start;
  logic [TW-1:0] end_pos;

  ssi_pkg::cell_ctl_t  ctl   [NP];
  ssi_pkg::cell_stat_t stat  [NP];
  logic [NP-1:0]       match_vec;
  logic [NP-1:0]       nxt_vec;
  logic [NP-1:0]       active;
  logic [NP-1:0]       top_sel;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign op       = ssi_pkg::op_t'(in_operation);
  assign chr      = in_char_value[ssi_pkg::CHAR_BITS-1:0];
  assign step     = in_acc && (op == ssi_pkg::OP_TEXT) &&
                    (text_r < TW'(ssi_pkg::MAX_TEXT));

  for (genvar k = 0; k < NP; k++) begin : g_cell
    logic prev;

    assign active[k]    = PW'(k) < pcount_r;
    assign top_sel[k]   = PW'(k + 1) == pcount_r;
    assign ctl[k].load  = in_acc && (op == ssi_pkg::OP_APPEND) && (pcount_r == PW'(k));
    assign ctl[k].clear = in_acc && (op != ssi_pkg::OP_TEXT);
    assign ctl[k].step  = step && active[k];
    assign match_vec[k] = stat[k].match;
    assign nxt_vec[k]   = stat[k].match_nxt;

    if (k == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = stat[k-1].match;
    end

    ssi_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl[k]),
      .char_value (chr),
      .prev_match (prev),
      .stat       (stat[k])
    );
  end

  assign hit     = step && |(nxt_vec & top_sel);
  assign start   = TW'(text_r - TW'(pcount_r) + TW'(2));
  assign end_pos = (pcount_r == '0) ? (in_search_backward ? TW'(text_r + TW'(1)) : TW'(1))
                                    : (in_search_backward ? last_r : first_r);

  always_comb begin
    pcount_nxt    = pcount_r;
    text_nxt      = text_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    pat_ovf_nxt   = pat_ovf_r;
    txt_ovf_nxt   = txt_ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pos_nxt   = out_pos_r;
    out_err_nxt   = out_err_r;
    if (in_acc) begin
      unique case (op)
        ssi_pkg::OP_CLEAR: begin
          pcount_nxt  = '0;
          pat_ovf_nxt = 1'b0;
          text_nxt    = '0;
          first_nxt   = '0;
          last_nxt    = '0;
          txt_ovf_nxt = 1'b0;
        end
        ssi_pkg::OP_APPEND: begin
          if (pcount_r < PW'(NP)) begin
            pcount_nxt = PW'(pcount_r + PW'(1));
          end else begin
            pat_ovf_nxt = 1'b1;
          end
          text_nxt    = '0;
          first_nxt   = '0;
          last_nxt    = '0;
          txt_ovf_nxt = 1'b0;
        end
        ssi_pkg::OP_TEXT: begin
          if (step) begin
            text_nxt = TW'(text_r + TW'(1));
            if (hit) begin
              if (first_r == '0) begin
                first_nxt = start;
              end
              last_nxt = start;
            end
          end else begin
            txt_ovf_nxt = 1'b1;
          end
        end
        ssi_pkg::OP_END: begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = ssi_pkg::POS_W'(end_pos);
          out_err_nxt   = {pat_ovf_r, txt_ovf_r};
          text_nxt      = '0;
          first_nxt     = '0;
          last_nxt      = '0;
          txt_ovf_nxt   = 1'b0;
        end
        default: begin
          out_valid_nxt = out_valid_r && out_stall;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r    <= '0;
      text_r      <= '0;
      first_r     <= '0;
      last_r      <= '0;
      pat_ovf_r   <= 1'b0;
      txt_ovf_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pcount_r    <= pcount_nxt;
      text_r      <= text_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      pat_ovf_r   <= pat_ovf_nxt;
      txt_ovf_r   <= txt_ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pos_r <= out_pos_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_match_position = out_pos_r;
  assign out_error_code     = out_err_r;

  `ASSERT_CLK(a_pcount_range, (pcount_r <= PW'(NP)), "pattern count beyond capacity")
  `ASSERT_CLK(a_idle_cells_clear, ((match_vec & ~active) == '0), "match bit set above pattern")
  `ASSERT_CLK(a_first_le_last, (first_r != '0) |-> (last_r >= first_r), "first after last match")
  `ASSERT_CLK(a_end_gives_beat, (in_acc && (op == ssi_pkg::OP_END)) |=> out_valid_r,
              "end of text without result beat")
  `ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (pcount_r == '0 && !out_valid_r),
                 "reset left state behind")

endmodule

`default_nettype wire

>>> hdl/ssi_cell.sv
// ----------------------------------------------------------------------------
// ssi_cell
// One pattern position: holds its pattern character and its prefix match bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssi_cell (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire ssi_pkg::cell_ctl_t               ctl,
  input  wire logic [ssi_pkg::CHAR_BITS-1:0]    char_value,
  input  wire logic                             prev_match,
  output ssi_pkg::cell_stat_t                   stat
);

  logic [ssi_pkg::CHAR_BITS-1:0] pat_r;
  logic                          match_r;
  logic                          match_nxt;
  logic                          eval;

  assign eval = prev_match && (pat_r == char_value);

  always_comb begin
    priority if (ctl.clear) begin
      match_nxt = 1'b0;
    end else if (ctl.step) begin
      match_nxt = eval;
    end else begin
      match_nxt = match_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pat_r <= char_value;
    end
  end

  assign stat.match     = match_r;
  assign stat.match_nxt = eval;

endmodule

`default_nettype wire
